>>> rtl/core/dhcp_request_classifier_macros.svh
// Assertion macros used by the classifier top level.
`ifndef DHCP_REQUEST_CLASSIFIER_MACROS_SVH
`define DHCP_REQUEST_CLASSIFIER_MACROS_SVH

// Condition that holds at every clock edge outside reset.
`define DRC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequence that holds in the cycle after the antecedent.
`define DRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/drc_pkg.sv
// Types and constants of the DHCP request classifier.
package drc_pkg;

  localparam int POS_W = 11;

  // Fixed payload offsets
  localparam logic [POS_W-1:0] OP_POS        = 11'd0;
  localparam logic [POS_W-1:0] YIADDR_FIRST  = 11'd16;
  localparam logic [POS_W-1:0] YIADDR_LAST   = 11'd19;
  localparam logic [POS_W-1:0] SNAME_POS     = 11'd44;
  localparam logic [POS_W-1:0] COOKIE_FIRST  = 11'd236;
  localparam logic [POS_W-1:0] COOKIE_LAST   = 11'd239;
  localparam logic [POS_W-1:0] OPTIONS_START = 11'd240;

  localparam logic [POS_W-1:0] MIN_LEN_RESET = 11'd236;

  localparam logic [7:0] OPT_PAD     = 8'd0;
  localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
  localparam logic [7:0] OP_BOOTREQUEST = 8'd1;
  localparam logic [7:0] MSG_BOOTP   = 8'd0;
  localparam logic [7:0] MSG_DISCOVER = 8'd1;
  localparam logic [7:0] MSG_REQUEST = 8'd3;

  // reply_kind codes
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_OFFER = 2'd1;
  localparam logic [1:0] KIND_ACK   = 2'd2;

  // verdict codes
  localparam logic [2:0] VERDICT_ANSWERED    = 3'd0;
  localparam logic [2:0] VERDICT_TOO_SHORT   = 3'd1;
  localparam logic [2:0] VERDICT_NOT_REQUEST = 3'd2;
  localparam logic [2:0] VERDICT_SNAME_SET   = 3'd3;
  localparam logic [2:0] VERDICT_ADDR_SET    = 3'd4;
  localparam logic [2:0] VERDICT_UNSUPPORTED = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0] reply_kind;
    logic [7:0] message_type;
    logic       cookie_seen;
    logic [2:0] verdict;
  } out_word_t;

  // Option walker control and status
  typedef struct packed {
    logic en;
    logic clear;
  } walk_ctrl_t;

  typedef struct packed {
    logic       found;
    logic [7:0] msg_type;
  } walk_status_t;

  // Magic cookie 99,130,83,99 by byte index
  function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'd99;
      2'd1:    b = 8'd130;
      2'd2:    b = 8'd83;
      default: b = 8'd99;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/core/drc_opt_walk.sv
// Option TLV walker: skips pads and other options, captures option 53.
module drc_opt_walk (
  input  logic                  clk,
  input  logic                  rst_n,
  input  drc_pkg::walk_ctrl_t   ctrl,
  input  logic [7:0]            data_byte,
  output drc_pkg::walk_status_t status
);
  import drc_pkg::*;

  localparam logic [1:0] PH_CODE = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_SKIP = 2'd2;
  localparam logic [1:0] PH_TYPE = 2'd3;

  logic [1:0] phase_r, phase_nxt;
  logic [7:0] skip_r, skip_nxt;
  logic       found_r, found_nxt;
  logic [7:0] type_r, type_nxt;
  logic [7:0] skip_dec;

  assign skip_dec = skip_r - 8'd1;

  // Next walk state for the current byte
  always_comb begin
    phase_nxt = phase_r;
    skip_nxt  = skip_r;
    found_nxt = found_r;
    type_nxt  = type_r;
    if (ctrl.en && !found_r) begin
      case (phase_r)
        PH_CODE: begin
          if (data_byte == OPT_PAD) begin
            phase_nxt = PH_CODE;
          end else if (data_byte == OPT_MSG_TYPE) begin
            phase_nxt = PH_TYPE;
            skip_nxt  = 8'd1;  // length byte pending
          end else begin
            phase_nxt = PH_LEN;
          end
        end
        PH_LEN: begin
          skip_nxt  = data_byte;
          phase_nxt = (data_byte == 8'd0) ? PH_CODE : PH_SKIP;
        end
        PH_SKIP: begin
          skip_nxt = skip_dec;
          if (skip_dec == 8'd0) begin
            phase_nxt = PH_CODE;
          end
        end
        PH_TYPE: begin
          if (skip_r != 8'd0) begin
            skip_nxt = 8'd0;  // length byte, value follows
          end else begin
            found_nxt = 1'b1;
            type_nxt  = data_byte;
            phase_nxt = PH_CODE;
          end
        end
        default: begin
          phase_nxt = PH_CODE;
        end
      endcase
    end
  end

  // Status includes the byte being walked this cycle
  assign status.found    = found_nxt;
  assign status.msg_type = type_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      phase_r <= PH_CODE;
      skip_r  <= 8'd0;
      found_r <= 1'b0;
      type_r  <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      skip_r  <= skip_nxt;
      found_r <= found_nxt;
      type_r  <= type_nxt;
    end
  end

endmodule

>>> rtl/core/dhcp_request_classifier.sv
// Top level: one-byte-per-cycle DHCP request parser and classifier.
// Pipeline: a word is held in the input register; the result for a last byte is
//   loaded into the output register when that byte leaves the input register.
// Throughput: one byte per cycle; the input register and the output register decouple
//   the two sides, so only a stalled pending result holds back a last byte.
// Reset: synchronous active-low rst_n clears packet state and valids; min length -> 236.
`include "dhcp_request_classifier_macros.svh"

module dhcp_request_classifier #(
  parameter int MAX_PACKET_BYTES = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  drc_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output drc_pkg::out_word_t out_word,
  input  logic               cfg_wr_en,
  input  logic [10:0]        cfg_wr_data
);
  import drc_pkg::*;

  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_PACKET_BYTES);

  // Input register
  logic      s1_valid_r;
  in_word_t  s1_word_r;
  logic      s1_adv;
  logic      in_accept;

  // Packet state
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       op_r, op_nxt;
  logic [7:0]       sname_r, sname_nxt;
  logic [31:0]      addr_r, addr_nxt;
  logic             cookie_r, cookie_nxt;
  logic [POS_W-1:0] min_len_r;

  // Output register
  logic      out_valid_r;
  out_word_t out_word_r, res_word;

  logic         take;
  logic         end_pkt;
  walk_ctrl_t   walk_ctrl;
  walk_status_t walk_status;
  logic         cookie_ok;
  logic [7:0]   mtype;
  logic         kind_ok;
  logic         type_ok;

  // Handshake: a last byte needs room in the output register
  assign s1_adv    = s1_valid_r && (!s1_word_r.last_byte || !out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;
  assign end_pkt   = s1_adv && s1_word_r.last_byte;

  // Byte capture by position; bytes past the limit are dropped
  assign take = s1_adv && (pos_r < MAX_POS);

  always_comb begin
    pos_nxt    = pos_r;
    op_nxt     = op_r;
    sname_nxt  = sname_r;
    addr_nxt   = addr_r;
    cookie_nxt = cookie_r;
    if (take) begin
      pos_nxt = pos_r + POS_W'(1);
      if (pos_r == OP_POS) begin
        op_nxt = s1_word_r.data_byte;
      end else if (pos_r >= YIADDR_FIRST && pos_r <= YIADDR_LAST) begin
        addr_nxt = {addr_r[23:0], s1_word_r.data_byte};
      end else if (pos_r == SNAME_POS) begin
        sname_nxt = s1_word_r.data_byte;
      end else if (pos_r >= COOKIE_FIRST && pos_r <= COOKIE_LAST) begin
        if (s1_word_r.data_byte != cookie_byte(pos_r[1:0])) begin
          cookie_nxt = 1'b0;
        end
      end
    end
  end

  assign walk_ctrl.en    = take && (pos_r >= OPTIONS_START);
  assign walk_ctrl.clear = end_pkt;

  drc_opt_walk u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (walk_ctrl),
    .data_byte (s1_word_r.data_byte),
    .status    (walk_status)
  );

  // Verdict from the state as it stands after this byte
  assign cookie_ok = cookie_nxt && (pos_nxt >= OPTIONS_START);
  assign mtype     = (cookie_ok && walk_status.found) ? walk_status.msg_type : 8'd0;

  always_comb begin
    res_word.message_type = mtype;
    res_word.cookie_seen  = cookie_ok;
    res_word.reply_kind   = KIND_NONE;
    if (pos_nxt < min_len_r) begin
      res_word.verdict = VERDICT_TOO_SHORT;
    end else if (sname_nxt != 8'd0) begin
      res_word.verdict = VERDICT_SNAME_SET;
    end else if (op_nxt != OP_BOOTREQUEST) begin
      res_word.verdict = VERDICT_NOT_REQUEST;
    end else if (addr_nxt != 32'd0 && addr_nxt != 32'hFFFF_FFFF) begin
      res_word.verdict = VERDICT_ADDR_SET;
    end else if (mtype == MSG_BOOTP || mtype == MSG_DISCOVER) begin
      res_word.verdict    = VERDICT_ANSWERED;
      res_word.reply_kind = KIND_OFFER;
    end else if (mtype == MSG_REQUEST) begin
      res_word.verdict    = VERDICT_ANSWERED;
      res_word.reply_kind = KIND_ACK;
    end else begin
      res_word.verdict = VERDICT_UNSUPPORTED;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
    if (in_accept) begin
      s1_word_r <= in_word;
    end
  end

  // Packet state; cleared once the last byte is classified
  always_ff @(posedge clk) begin
    if (!rst_n || end_pkt) begin
      pos_r    <= '0;
      op_r     <= 8'd0;
      sname_r  <= 8'd0;
      addr_r   <= 32'd0;
      cookie_r <= 1'b1;
    end else begin
      pos_r    <= pos_nxt;
      op_r     <= op_nxt;
      sname_r  <= sname_nxt;
      addr_r   <= addr_nxt;
      cookie_r <= cookie_nxt;
    end
  end

  // Config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= MIN_LEN_RESET;
    end else if (cfg_wr_en) begin
      min_len_r <= cfg_wr_data;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (end_pkt) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (end_pkt) begin
      out_word_r <= res_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Checks
  assign kind_ok = (out_word_r.reply_kind != KIND_NONE) ==
                   (out_word_r.verdict == VERDICT_ANSWERED);
  assign type_ok = (out_word_r.message_type == 8'd0) || out_word_r.cookie_seen;

  `DRC_ASSERT_ALWAYS(a_kind_matches_verdict, !out_valid_r || kind_ok, "reply kind vs verdict")
  `DRC_ASSERT_ALWAYS(a_type_needs_cookie, !out_valid_r || type_ok, "type without cookie")
  `DRC_ASSERT_NEXT(a_pos_cleared, end_pkt, pos_r == '0 && cookie_r, "packet state not cleared")
  `DRC_ASSERT_NEXT(a_result_loaded, end_pkt, out_valid_r, "result word not loaded")

endmodule

>>> verif/tb.sv
// Self-checking testbench for the DHCP request classifier: directed packets, then random ones.
module tb;
  import drc_pkg::*;

  localparam int MAX_BYTES = 256;
  localparam int LONG_HOLD = 300;
  localparam int IDLE_LIMIT = 5000;
  localparam int PACKETS_PER_PHASE = 2;
  localparam int PRESSURE_PACKETS = 12;
  localparam logic [31:0] MAGIC_COOKIE = 32'h6382_5363;
  localparam logic [10:0] DIRECTED_MIN_LEN = 11'd20;

  typedef enum logic [1:0] {WALK_CODE, WALK_LEN, WALK_SKIP, WALK_TYPE} walk_phase_t;

  // One directed packet: header fields, option bytes (first byte in the top bits)
  typedef struct packed {
    int          len;
    logic [7:0]  op;
    logic [31:0] yiaddr;
    logic [7:0]  sname;
    logic        cookie_good;
    logic [3:0]  n_opt;
    logic [63:0] opts;
    logic        typed;
    out_word_t   want;
  } packet_case_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;
  logic cfg_wr_en = 1'b0;
  logic [10:0] cfg_wr_data = '0;

  // Classifier model state
  logic [10:0] min_len;
  logic [10:0] byte_pos;
  logic [7:0] op_seen;
  logic [7:0] sname_seen;
  logic [31:0] yiaddr_seen;
  logic cookie_ok;
  walk_phase_t walk_phase;
  logic [7:0] skip_left;
  logic type_found;
  logic [7:0] type_val;

  out_word_t expected_verdicts[$];
  logic [7:0] packet_bytes[$];
  int mismatch_count = 0;
  int idle_cycles = 0;
  bit hold_request = 1'b0;
  bit send_quiet = 1'b0;
  bit force_quiet = 1'b0;
  bit sink_quiet = 1'b0;

  // Directed packets, run under a minimum length of 20
  packet_case_t directed_packets [9] = '{
    '{1, 8'h00, 32'h0, 8'h00, 1'b0, 4'd0, 64'h0, 1'b1,
      '{KIND_NONE, MSG_BOOTP, 1'b0, VERDICT_TOO_SHORT}},
    '{19, OP_BOOTREQUEST, 32'h0, 8'h00, 1'b0, 4'd0, 64'h0, 1'b1,
      '{KIND_NONE, MSG_BOOTP, 1'b0, VERDICT_TOO_SHORT}},
    '{20, OP_BOOTREQUEST, 32'h0, 8'h00, 1'b0, 4'd0, 64'h0, 1'b1,
      '{KIND_OFFER, MSG_BOOTP, 1'b0, VERDICT_ANSWERED}},
    '{45, 8'h02, 32'h0, 8'hFF, 1'b0, 4'd0, 64'h0, 1'b1,
      '{KIND_NONE, MSG_BOOTP, 1'b0, VERDICT_SNAME_SET}},
    '{45, 8'hFF, 32'h0, 8'h00, 1'b0, 4'd0, 64'h0, 1'b1,
      '{KIND_NONE, MSG_BOOTP, 1'b0, VERDICT_NOT_REQUEST}},
    '{20, OP_BOOTREQUEST, 32'hFFFF_FFFF, 8'h00, 1'b0, 4'd0, 64'h0, 1'b1,
      '{KIND_OFFER, MSG_BOOTP, 1'b0, VERDICT_ANSWERED}},
    '{20, OP_BOOTREQUEST, 32'h0A00_0001, 8'h00, 1'b0, 4'd0, 64'h0, 1'b1,
      '{KIND_NONE, MSG_BOOTP, 1'b0, VERDICT_ADDR_SET}},
    // address cut off after two bytes
    '{18, OP_BOOTREQUEST, 32'h0A00_0001, 8'h00, 1'b0, 4'd0, 64'h0, 1'b0, '0},
    // pad, end option whose value holds a 53, then the message type
    '{247, OP_BOOTREQUEST, 32'h0, 8'h00, 1'b1, 4'd7, 64'h00FF_0135_3501_0300, 1'b0, '0}
  };

  // Minimum length plan for the random phases; -1 picks a random value
  int min_len_plan [4] = '{0, 45, 240, -1};

  dhcp_request_classifier #(.MAX_PACKET_BYTES(MAX_BYTES)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Model: per-packet state back to its start
  task automatic clear_packet_state();
    byte_pos = '0;
    op_seen = '0;
    sname_seen = '0;
    yiaddr_seen = '0;
    cookie_ok = 1'b1;
    walk_phase = WALK_CODE;
    skip_left = '0;
    type_found = 1'b0;
    type_val = '0;
  endtask

  // Model: option TLV walk, one byte
  task automatic walk_option(input logic [7:0] b);
    if (!type_found) begin
      case (walk_phase)
        WALK_CODE: begin
          if (b == OPT_MSG_TYPE) begin
            walk_phase = WALK_TYPE;
            skip_left = 8'd1;
          end else if (b != OPT_PAD) begin
            walk_phase = WALK_LEN;
          end
        end
        WALK_LEN: begin
          skip_left = b;
          walk_phase = (b == 8'd0) ? WALK_CODE : WALK_SKIP;
        end
        WALK_SKIP: begin
          skip_left = skip_left - 8'd1;
          if (skip_left == 8'd0) walk_phase = WALK_CODE;
        end
        default: begin
          if (skip_left != 8'd0) begin
            skip_left = 8'd0;
          end else begin
            type_found = 1'b1;
            type_val = b;
            walk_phase = WALK_CODE;
          end
        end
      endcase
    end
  endtask

  // Model: one accepted word; done is set with the verdict on a last byte
  task automatic classify_byte(input logic [7:0] b, input logic last,
                               output logic done, output out_word_t res);
    logic cookie;
    logic [7:0] mtype;
    res = '0;
    done = last;
    if (byte_pos < MAX_BYTES) begin
      if (byte_pos == OP_POS) op_seen = b;
      else if (byte_pos >= YIADDR_FIRST && byte_pos <= YIADDR_LAST)
        yiaddr_seen = {yiaddr_seen[23:0], b};
      else if (byte_pos == SNAME_POS) sname_seen = b;
      else if (byte_pos >= COOKIE_FIRST && byte_pos <= COOKIE_LAST) begin
        if (b != MAGIC_COOKIE[31 - 8 * (byte_pos - COOKIE_FIRST) -: 8]) cookie_ok = 1'b0;
      end else if (byte_pos >= OPTIONS_START) walk_option(b);
      byte_pos = byte_pos + 11'd1;
    end
    if (last) begin
      cookie = cookie_ok && (byte_pos >= OPTIONS_START);
      mtype = (cookie && type_found) ? type_val : 8'd0;
      res.message_type = mtype;
      res.cookie_seen = cookie;
      res.reply_kind = KIND_NONE;
      if (byte_pos < min_len) res.verdict = VERDICT_TOO_SHORT;
      else if (sname_seen != 8'd0) res.verdict = VERDICT_SNAME_SET;
      else if (op_seen != OP_BOOTREQUEST) res.verdict = VERDICT_NOT_REQUEST;
      else if (yiaddr_seen != 32'd0 && yiaddr_seen != 32'hFFFF_FFFF)
        res.verdict = VERDICT_ADDR_SET;
      else if (mtype == MSG_BOOTP || mtype == MSG_DISCOVER) begin
        res.verdict = VERDICT_ANSWERED;
        res.reply_kind = KIND_OFFER;
      end else if (mtype == MSG_REQUEST) begin
        res.verdict = VERDICT_ANSWERED;
        res.reply_kind = KIND_ACK;
      end else res.verdict = VERDICT_UNSUPPORTED;
      clear_packet_state();
    end
  endtask

  task automatic report_mismatch(input string what, input out_word_t want, input out_word_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t mismatch, %s: want kind %0d type %0d cookie %0d verdict %0d,",
               $realtime, what, want.reply_kind, want.message_type, want.cookie_seen,
               want.verdict, " got kind %0d type %0d cookie %0d verdict %0d",
               got.reply_kind, got.message_type, got.cookie_seen, got.verdict);
  endtask

  task automatic check_verdict(input out_word_t got);
    out_word_t want;
    if (expected_verdicts.size() == 0) begin
      report_mismatch("result with nothing expected", '0, got);
    end else begin
      want = expected_verdicts.pop_front();
      if (got.reply_kind !== want.reply_kind || got.message_type !== want.message_type ||
          got.cookie_seen !== want.cookie_seen || got.verdict !== want.verdict)
        report_mismatch("field differs", want, got);
    end
  endtask

  // Drive one word; called at a falling edge, returns at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                           input out_word_t want);
    int gap;
    logic done;
    out_word_t res;
    gap = (send_quiet || force_quiet) ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word <= '{data_byte: b, last_byte: last};
    do @(posedge clk); while (in_stall);
    classify_byte(b, last, done, res);
    if (done) expected_verdicts.push_back(typed ? want : res);
    @(negedge clk);
  endtask

  task automatic send_packet(input logic typed, input out_word_t want);
    if ($urandom_range(0, 3) == 0) send_quiet = !send_quiet;
    foreach (packet_bytes[i])
      send_byte(packet_bytes[i], i == packet_bytes.size() - 1, typed, want);
  endtask

  task automatic put(input int pos, input logic [7:0] b);
    if (pos < packet_bytes.size()) packet_bytes[pos] = b;
  endtask

  // Random packet: mostly short headers, now and then a full one that may pass the
  // byte limit; some pure noise
  task automatic make_packet();
    int len;
    int r;
    int k;
    logic [31:0] yi;
    logic [7:0] opt_q[$];
    packet_bytes.delete();
    r = $urandom_range(0, 7);
    if (r == 0) len = $urandom_range(240, 290);
    else len = $urandom_range(1, 47);
    for (int i = 0; i < len; i++) packet_bytes.push_back(8'($urandom));
    if ($urandom_range(0, 9) != 0) begin
      put(OP_POS, ($urandom_range(0, 7) != 0) ? OP_BOOTREQUEST : 8'($urandom));
      r = $urandom_range(0, 5);
      yi = (r < 4) ? 32'd0 : (r == 4) ? 32'hFFFF_FFFF : $urandom;
      for (int i = 0; i < 4; i++) put(YIADDR_FIRST + i, yi[31 - 8 * i -: 8]);
      put(SNAME_POS, ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255)) : 8'd0);
      for (int i = 0; i < 4; i++) put(COOKIE_FIRST + i, MAGIC_COOKIE[31 - 8 * i -: 8]);
      if ($urandom_range(0, 7) == 0) put(COOKIE_FIRST + $urandom_range(0, 3), 8'($urandom));
      // option list, possibly cut off by the packet end
      while (opt_q.size() + OPTIONS_START < len) begin
        r = $urandom_range(0, 9);
        if (r < 2) begin
          opt_q.push_back(OPT_PAD);
        end else if (r < 5) begin
          opt_q.push_back(OPT_MSG_TYPE);
          opt_q.push_back(($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 3)) : 8'd1);
          k = $urandom_range(0, 5);
          opt_q.push_back((k < 2) ? MSG_DISCOVER : (k < 4) ? MSG_REQUEST :
                          (k == 4) ? MSG_BOOTP : 8'($urandom));
        end else begin
          k = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
          opt_q.push_back(8'($urandom_range(1, 255)));
          opt_q.push_back(8'(k));
          repeat (k) opt_q.push_back(8'($urandom));
        end
      end
      foreach (opt_q[i]) put(OPTIONS_START + i, opt_q[i]);
    end
  endtask

  // Directed packet: header filler random, option area padded after the listed options
  task automatic build_case(input packet_case_t c);
    packet_bytes.delete();
    for (int i = 0; i < c.len; i++)
      packet_bytes.push_back((i >= OPTIONS_START) ? OPT_PAD : 8'($urandom));
    put(OP_POS, c.op);
    for (int i = 0; i < 4; i++) put(YIADDR_FIRST + i, c.yiaddr[31 - 8 * i -: 8]);
    put(SNAME_POS, c.sname);
    for (int i = 0; i < 4; i++) put(COOKIE_FIRST + i, MAGIC_COOKIE[31 - 8 * i -: 8]);
    if (!c.cookie_good) put(COOKIE_FIRST + 1, 8'h00);
    for (int i = 0; i < c.n_opt; i++) put(OPTIONS_START + i, c.opts[63 - 8 * i -: 8]);
  endtask

  // Wait for all verdicts plus pipeline slack; called and returns at a falling edge
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_min_len(input logic [10:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    min_len = value;
  endtask

  // Stimulus and end of run
  initial begin : stimulus
    int value;
    min_len = MIN_LEN_RESET;
    clear_packet_state();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    write_min_len(DIRECTED_MIN_LEN);
    foreach (directed_packets[i]) begin
      build_case(directed_packets[i]);
      send_packet(directed_packets[i].typed, directed_packets[i].want);
    end

    foreach (min_len_plan[p]) begin
      drain();
      value = (min_len_plan[p] < 0) ? $urandom_range(0, 1024) : min_len_plan[p];
      write_min_len(11'(value));
      // block fills up behind a held result, sender keeps offering
      if (p == 0) begin
        hold_request = 1'b1;
        force_quiet = 1'b1;
        repeat (PRESSURE_PACKETS) begin
          packet_bytes.delete();
          repeat ($urandom_range(1, 4)) packet_bytes.push_back(8'($urandom));
          if ($urandom_range(0, 1) == 1) packet_bytes[0] = OP_BOOTREQUEST;
          send_packet(1'b0, '0);
        end
        force_quiet = 1'b0;
      end
      repeat (PACKETS_PER_PHASE) begin
        make_packet();
        send_packet(1'b0, '0);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (out_valid) report_mismatch("result with nothing expected", '0, out_word);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Result side: random stall per result, one long hold on request
  initial begin : result_sink
    int gap;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        gap = LONG_HOLD;
        hold_request = 1'b0;
      end else begin
        if ($urandom_range(0, 9) == 0) sink_quiet = !sink_quiet;
        gap = sink_quiet ? 0 : $urandom_range(0, 19);
      end
      if (gap == 0) begin
        out_stall <= 1'b0;
        do @(posedge clk); while (!out_valid);
      end else begin
        out_stall <= 1'b1;
        do @(posedge clk); while (!out_valid);
        repeat (gap) @(negedge clk);
        out_stall <= 1'b0;
        do @(posedge clk); while (!out_valid);
      end
      check_verdict(out_word);
    end
  end

  // Watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
